// File: rtl/lpid_pkg.sv
package lpid_pkg;

    localparam int CordicItersDefault = 16;
    localparam int CfgIdxW = 3;
    localparam int CfgDataW = 31;

    localparam logic [CfgIdxW-1:0] REG_PROP_GAIN = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_INTEG_GAIN = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_DERIV_GAIN = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_WINDUP_LIMIT = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_OUTPUT_LIMIT = 3'd4;
    localparam logic [CfgIdxW-1:0] REG_LOOKAHEAD = 3'd5;

    typedef struct packed {
        logic               cmd;
        logic signed [15:0] line_offset;
    } t_in;

    typedef struct packed {
        logic signed [15:0] steering;
        logic               clamped;
    } t_out;

    // arctangent of 2^-i in Q.24, rounded
    function automatic logic [23:0] atan_q24(input logic [4:0] i);
        logic [23:0] v;
        unique case (i)
            5'd0:  v = 24'd13176795;
            5'd1:  v = 24'd7778716;
            5'd2:  v = 24'd4110060;
            5'd3:  v = 24'd2086331;
            5'd4:  v = 24'd1047214;
            5'd5:  v = 24'd524117;
            5'd6:  v = 24'd262123;
            5'd7:  v = 24'd131069;
            5'd8:  v = 24'd65536;
            5'd9:  v = 24'd32768;
            5'd10: v = 24'd16384;
            5'd11: v = 24'd8192;
            5'd12: v = 24'd4096;
            5'd13: v = 24'd2048;
            5'd14: v = 24'd1024;
            5'd15: v = 24'd512;
            5'd16: v = 24'd256;
            5'd17: v = 24'd128;
            5'd18: v = 24'd64;
            5'd19: v = 24'd32;
            5'd20: v = 24'd16;
            5'd21: v = 24'd8;
            5'd22: v = 24'd4;
            5'd23: v = 24'd2;
            default: v = 24'd0;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/lookahead_pid_steering.sv
// Lookahead PID steering.
// Input channel (i_in_valid/o_in_ready) takes a request {cmd, line_offset}.
// cmd = 1 clears the integral and previous angle and answers steering 0.
// cmd = 0 forms atan2(line_offset, lookahead) by CORDIC, then runs the PID.
// Output channel (o_out_valid/i_out_ready) returns one {steering, clamped}
// per request, held in an output register until taken.
// Sequence: a clear answers in the cycle after acceptance. A control step runs
// the shift-add CORDIC loop (one iteration per cycle, then the angle rounding),
// the divide by 100 (a setup step, then one quotient bit per cycle over 28
// bits), then the gain multiplies, the sum and the saturation; when offset and
// lookahead are both zero the CORDIC iterations and the divide setup are skipped.
// One request is in work at a time; the next is taken in the idle cycle after
// the result is in the output register, once that register is free or being
// emptied, so a stalled receiver holds back one request. Reset (synchronous,
// active low) restores the register defaults and zeroes the integral and
// previous angle. Registers are written through i_cfg_we, i_cfg_idx and
// i_cfg_data; the user must write them only while the block is idle, as the
// block itself does not enforce it.
module lookahead_pid_steering #(
    parameter int CORDIC_ITERATIONS = lpid_pkg::CordicItersDefault
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  lpid_pkg::t_in                 i_in,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output lpid_pkg::t_out                o_out,
    input  logic                          i_cfg_we,
    input  logic [lpid_pkg::CfgIdxW-1:0]  i_cfg_idx,
    input  logic [lpid_pkg::CfgDataW-1:0] i_cfg_data
);
    import lpid_pkg::*;

    localparam int ItW = $clog2(CORDIC_ITERATIONS + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_CORDIC, S_DIV, S_MUL, S_SUM, S_SAT
    } t_state;

    t_state r_state;

    logic [15:0] r_kp, r_ki, r_kd;
    logic [30:0] r_wlim;
    logic [14:0] r_olim, r_look;

    logic signed [31:0] r_integ;
    logic signed [15:0] r_prev;

    logic signed [29:0] r_x, r_y;
    logic signed [25:0] r_z;
    logic [ItW-1:0]     r_it;

    logic signed [15:0] r_ang;
    logic               r_neg;
    logic [15:0]        r_rem;
    logic [27:0]        r_quo;
    logic [27:0]        r_num;
    logic [4:0]         r_dcnt;

    logic signed [48:0] r_pp, r_ip, r_dp;
    logic signed [50:0] r_sum;

    logic   r_ovalid;
    logic   n_ovalid;
    t_out   r_out;

    // CORDIC step
    logic signed [29:0] xs, ys;
    logic [23:0]        at;
    always_comb begin
        xs = r_x >>> r_it;
        ys = r_y >>> r_it;
        at = atan_q24(5'(r_it));
    end

    // restoring divide step on the magnitude numerator
    logic [16:0] rem_sh;
    logic        q_bit;
    always_comb begin
        rem_sh = {r_rem, r_num[27]};
        q_bit  = rem_sh >= 17'd100;
    end

    // integral update after division
    logic signed [28:0] inc;
    logic signed [33:0] acc_raw, acc_cl;
    always_comb begin
        inc = r_neg ? -$signed({1'b0, r_quo}) : $signed({1'b0, r_quo});
        acc_raw = 34'(r_integ) + 34'(inc);
        acc_cl  = acc_raw;
        if (acc_raw > $signed({3'b0, r_wlim})) acc_cl = $signed({3'b0, r_wlim});
        if (acc_raw < -$signed({3'b0, r_wlim})) acc_cl = -$signed({3'b0, r_wlim});
    end

    // rounding and saturation
    logic signed [27:0] s_rnd;
    logic signed [27:0] lim;
    always_comb begin
        s_rnd = 28'((r_sum + 51'sd4194304) >>> 23);
        lim   = $signed({13'b0, r_olim});
    end

    logic signed [26:0] num_s;
    logic signed [16:0] dang;
    always_comb begin
        num_s = 27'(r_ang) * 27'sd2048 + 27'sd50;
        dang  = 17'(r_ang) - 17'(r_prev);
    end

    // drop the result once taken; load on a clear or at the end of a step
    always_comb begin
        n_ovalid = r_ovalid && !i_out_ready;
        if (i_in_valid && o_in_ready && i_in.cmd) n_ovalid = 1'b1;
        if (r_state == S_SAT) n_ovalid = 1'b1;
    end

    assign o_in_ready  = (r_state == S_IDLE) && (!r_ovalid || i_out_ready);
    assign o_out_valid = r_ovalid;
    assign o_out       = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_kp     <= 16'd6144;
            r_ki     <= 16'd82;
            r_kd     <= 16'd492;
            r_wlim   <= 31'd8388608;
            r_olim   <= 15'd12288;
            r_look   <= 15'd1966;
            r_integ  <= '0;
            r_prev   <= '0;
        end else begin
            r_ovalid <= n_ovalid;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_PROP_GAIN:    r_kp   <= i_cfg_data[15:0];
                    REG_INTEG_GAIN:   r_ki   <= i_cfg_data[15:0];
                    REG_DERIV_GAIN:   r_kd   <= i_cfg_data[15:0];
                    REG_WINDUP_LIMIT: r_wlim <= i_cfg_data;
                    REG_OUTPUT_LIMIT: r_olim <= i_cfg_data[14:0];
                    REG_LOOKAHEAD:    r_look <= i_cfg_data[14:0];
                    default: ;
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid && o_in_ready) begin
                        if (i_in.cmd) begin
                            r_integ  <= '0;
                            r_prev   <= '0;
                            r_out    <= '0;
                        end else begin
                            r_x     <= {5'b0, r_look, 10'b0};
                            r_y     <= {{4{i_in.line_offset[15]}}, i_in.line_offset, 10'b0};
                            r_z     <= '0;
                            r_it    <= '0;
                            r_state <= S_CORDIC;
                        end
                    end
                end
                S_CORDIC: begin
                    if (r_x == '0 && r_y == '0 && r_it == '0) begin
                        r_ang   <= '0;
                        r_state <= S_DIV;
                        r_rem   <= '0;
                        r_dcnt  <= '0;
                        r_num   <= '0;
                        r_neg   <= 1'b0;
                    end else if (r_it == ItW'(CORDIC_ITERATIONS)) begin
                        r_ang   <= 16'((27'(r_z) + 27'sd1024) >>> 11);
                        r_state <= S_DIV;
                        r_dcnt  <= 5'd31;
                    end else begin
                        if (!r_y[29]) begin
                            r_x <= r_x + ys;
                            r_y <= r_y - xs;
                            r_z <= r_z + $signed({2'b0, at});
                        end else begin
                            r_x <= r_x - ys;
                            r_y <= r_y + xs;
                            r_z <= r_z - $signed({2'b0, at});
                        end
                        r_it <= r_it + 1'b1;
                    end
                end
                S_DIV: begin
                    if (r_dcnt == 5'd31) begin
                        // floor for positive, ceil of magnitude for negative
                        r_neg <= num_s[26];
                        r_num <= num_s[26] ? 28'(-28'(num_s) + 28'sd99) : 28'(num_s);
                        r_rem <= '0;
                        r_quo <= '0;
                        r_dcnt <= '0;
                    end else begin
                        r_rem  <= q_bit ? 16'(rem_sh - 17'd100) : rem_sh[15:0];
                        r_quo  <= {r_quo[26:0], q_bit};
                        r_num  <= {r_num[26:0], 1'b0};
                        r_dcnt <= r_dcnt + 1'b1;
                        if (r_dcnt == 5'd27) r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_integ <= 32'(acc_cl);
                    r_pp    <= 49'($signed({1'b0, r_kp})) * 49'(r_ang) * 49'sd2048;
                    r_ip    <= 49'($signed({1'b0, r_ki})) * 49'(acc_cl);
                    r_dp    <= 49'($signed({1'b0, r_kd})) * 49'(dang);
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_sum   <= 51'(r_pp) + 51'(r_ip) + 51'(r_dp) * 51'sd204800;
                    r_prev  <= r_ang;
                    r_state <= S_SAT;
                end
                S_SAT: begin
                    if (s_rnd > lim) begin
                        r_out <= '{steering: 16'(lim), clamped: 1'b1};
                    end else if (s_rnd < -lim) begin
                        r_out <= '{steering: 16'(-lim), clamped: 1'b1};
                    end else begin
                        r_out <= '{steering: 16'(s_rnd), clamped: 1'b0};
                    end
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> r_state == S_IDLE) else $error("ready outside idle");
    a_integ_lim: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_SUM |-> (r_integ <= $signed({1'b0, r_wlim}) &&
        r_integ >= -$signed({1'b0, r_wlim}))) else $error("integral over limit");
    a_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_in.cmd) |=> (r_integ == 0 && r_prev == 0
        && o_out_valid)) else $error("clear failed");
    a_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) && o_out.clamped |-> (o_out.steering == 16'(r_olim) ||
        o_out.steering == -16'(r_olim))) else $error("clamp flag without limit");

endmodule

// File: sim/lookahead_pid_steering_tb.sv
module lookahead_pid_steering_tb;
    import lpid_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int Iters = CordicItersDefault;
    localparam longint unsigned CycleLimit = 2_000_000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    t_in i_in = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_out o_out;
    logic i_cfg_we = 1'b0;
    logic [CfgIdxW-1:0] i_cfg_idx = '0;
    logic [CfgDataW-1:0] i_cfg_data = '0;

    lookahead_pid_steering #(.CORDIC_ITERATIONS(Iters)) dut (.*);

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // predictor state and register copy
    logic [15:0] kp, ki, kd;
    logic [30:0] wlim;
    logic [14:0] olim, look;
    longint integ_acc, prev_angle;

    t_in pending_req[$];
    t_out steer_expected[$];
    int errors = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_off = 0;
    longint unsigned cycles = 0;

    function automatic longint asr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint heading(longint yoff);
        longint x, y, z, xs, ys;
        x = longint'(look) * 1024;
        y = yoff * 1024;
        z = 0;
        if (x == 0 && y == 0) return 0;
        for (int i = 0; i < Iters && i < 24; i++) begin
            xs = asr(x, i);
            ys = asr(y, i);
            if (y >= 0) begin
                x += ys; y -= xs; z += longint'(atan_q24(5'(i)));
            end else begin
                x -= ys; y += xs; z -= longint'(atan_q24(5'(i)));
            end
        end
        return asr(z + 1024, 11);
    endfunction

    function automatic t_out steer_step(t_in req);
        t_out r;
        longint a, num, inc, acc, w, lim, sum, s;
        r = '0;
        if (req.cmd) begin
            integ_acc = 0;
            prev_angle = 0;
            return r;
        end
        a = heading(longint'(req.line_offset));
        num = a * 2048 + 50;
        if (num >= 0) inc = num / 100;
        else inc = -((-num + 99) / 100);
        acc = integ_acc + inc;
        w = longint'(wlim);
        if (acc > w) acc = w;
        if (acc < -w) acc = -w;
        integ_acc = acc;
        sum = longint'(kp) * a * 2048 + longint'(ki) * acc
            + longint'(kd) * (a - prev_angle) * 100 * 2048;
        prev_angle = a;
        s = asr(sum + 4194304, 23);
        lim = longint'(olim);
        if (s > lim) begin s = lim; r.clamped = 1'b1; end
        if (s < -lim) begin s = -lim; r.clamped = 1'b1; end
        r.steering = 16'(s);
        return r;
    endfunction

    // driver: the front of the queue is the request on the bus
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (!i_in_valid || o_in_ready) begin
                if (i_in_valid) void'(pending_req.pop_front());
                if (pending_req.size() > 0) begin
                    if ($urandom_range(99) >= send_idle_pct) begin
                        i_in_valid <= 1'b1;
                        i_in <= pending_req[0];
                    end else begin
                        i_in_valid <= 1'b0;
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // predict on acceptance
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && o_in_ready) steer_expected.push_back(steer_step(i_in));
    end

    // receiver and monitor
    always @(posedge i_clk) begin
        t_out exp_r;
        cycles <= cycles + 1;
        if (hold_off > 0) hold_off <= hold_off - 1;
        if (i_rst_n) begin
            i_out_ready <= (hold_off <= 1) && ($urandom_range(99) >= recv_stall_pct);
            if (o_out_valid && i_out_ready) begin
                if (steer_expected.size() == 0) begin
                    $error("result with nothing expected: steering %0d", o_out.steering);
                    errors++;
                end else begin
                    exp_r = steer_expected.pop_front();
                    if (o_out.steering !== exp_r.steering) begin
                        $error("steering expected %0d got %0d", exp_r.steering,
                               o_out.steering);
                        errors++;
                    end
                    if (o_out.clamped !== exp_r.clamped) begin
                        $error("clamped expected %0b got %0b", exp_r.clamped, o_out.clamped);
                        errors++;
                    end
                end
            end
        end
        if (cycles > CycleLimit) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic cfg_write(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            REG_PROP_GAIN: kp = val[15:0];
            REG_INTEG_GAIN: ki = val[15:0];
            REG_DERIV_GAIN: kd = val[15:0];
            REG_WINDUP_LIMIT: wlim = val[30:0];
            REG_OUTPUT_LIMIT: olim = val[14:0];
            REG_LOOKAHEAD: look = val[14:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        wait (pending_req.size() == 0 && !i_in_valid && steer_expected.size() == 0);
        repeat (60) @(posedge i_clk);
    endtask

    task automatic add_req(logic cmd, logic [15:0] off);
        t_in r;
        r.cmd = cmd;
        r.line_offset = off;
        pending_req.push_back(r);
    endtask

    task automatic add_random(int n);
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(3))
                0: add_req($urandom_range(19) == 0, 16'($urandom));
                1: add_req($urandom_range(19) == 0, 16'($signed($urandom_range(2000)) - 1000));
                2: add_req(1'b0, 16'($signed($urandom_range(200)) - 100));
                default: add_req(1'b0, $urandom_range(1) ? 16'h7FFF - 16'($urandom_range(50))
                                                       : 16'h8000 + 16'($urandom_range(50)));
            endcase
        end
    endtask

    initial begin
        kp = 16'd6144; ki = 16'd82; kd = 16'd492;
        wlim = 31'd8388608; olim = 15'd12288; look = 15'd1966;
        integ_acc = 0; prev_angle = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, clear, zero offset, sign flips
        add_req(1'b0, 16'h0000);
        add_req(1'b0, 16'h7FFF);
        add_req(1'b0, 16'h8000);
        add_req(1'b0, 16'h0001);
        add_req(1'b0, 16'hFFFF);
        add_req(1'b1, 16'h1234);
        add_req(1'b0, 16'h0800);
        add_req(1'b0, 16'hF800);
        add_req(1'b1, 16'hFFFF);
        for (int k = 0; k < 8; k++) add_req(1'b0, 16'h7FFF);
        drain();

        // zero lookahead and extreme registers
        cfg_write(REG_LOOKAHEAD, 31'd0);
        cfg_write(REG_PROP_GAIN, 31'hFFFF);
        cfg_write(REG_INTEG_GAIN, 31'hFFFF);
        cfg_write(REG_DERIV_GAIN, 31'hFFFF);
        cfg_write(REG_WINDUP_LIMIT, 31'h7FFFFFFF);
        cfg_write(REG_OUTPUT_LIMIT, 31'h7FFF);
        add_req(1'b0, 16'h0000);
        add_req(1'b0, 16'h0005);
        add_req(1'b0, 16'hFFFB);
        add_req(1'b1, 16'h0000);
        add_random(120);
        drain();

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct = (ph == 1) ? 68 : (ph == 3) ? 32 : 0;
            recv_stall_pct = (ph == 2) ? 68 : (ph == 3) ? 32 : 0;
            case (ph)
                0: begin
                    cfg_write(REG_PROP_GAIN, 31'd0);
                    cfg_write(REG_INTEG_GAIN, 31'd0);
                    cfg_write(REG_DERIV_GAIN, 31'd0);
                    cfg_write(REG_WINDUP_LIMIT, 31'd0);
                    cfg_write(REG_OUTPUT_LIMIT, 31'd0);
                    cfg_write(REG_LOOKAHEAD, 31'h7FFF);
                end
                default: begin
                    cfg_write(REG_PROP_GAIN, 31'($urandom));
                    cfg_write(REG_INTEG_GAIN, 31'($urandom));
                    cfg_write(REG_DERIV_GAIN, 31'($urandom_range(4000)));
                    cfg_write(REG_WINDUP_LIMIT, 31'($urandom));
                    cfg_write(REG_OUTPUT_LIMIT, 31'($urandom_range(1, 32767)));
                    cfg_write(REG_LOOKAHEAD, 31'($urandom_range(1, 32767)));
                end
            endcase
            if (ph == 2) hold_off = 400;
            add_random(200);
            drain();
        end

        // back to defaults, with no sender idles or receiver stalls
        send_idle_pct = 0;
        recv_stall_pct = 0;
        cfg_write(REG_PROP_GAIN, 31'd6144);
        cfg_write(REG_INTEG_GAIN, 31'd82);
        cfg_write(REG_DERIV_GAIN, 31'd492);
        cfg_write(REG_WINDUP_LIMIT, 31'd8388608);
        cfg_write(REG_OUTPUT_LIMIT, 31'd12288);
        cfg_write(REG_LOOKAHEAD, 31'd1966);
        add_random(20);
        drain();

        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

// File: sim.f
rtl/lpid_pkg.sv
rtl/lookahead_pid_steering.sv
sim/lookahead_pid_steering_tb.sv
